// File: rtl/lng_pkg.sv
// Shared types, constants and direction tables of the lattice neighbour generator.
`timescale 1ns / 1ps

package lng_pkg;

  localparam int COORD_W   = 11;
  localparam int DEPTH_W   = 5;
  localparam int DIR_W     = 3;
  localparam int REG_IDX_W = 2;
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;
  localparam int PROD_W    = 2 * COORD_W + DEPTH_W;

  localparam logic KIND_SQUARE = 1'b0;
  localparam logic KIND_TRI    = 1'b1;

  localparam logic [REG_IDX_W-1:0] REG_KIND   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_HEIGHT = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_DEPTH  = 2'd3;

  localparam logic [DIR_W-1:0] NDIR_SQUARE = 3'd4;
  localparam logic [DIR_W-1:0] NDIR_TRI    = 3'd6;

  localparam logic signed [1:0] STEP_POS  = 2'sb01;
  localparam logic signed [1:0] STEP_ZERO = 2'sb00;
  localparam logic signed [1:0] STEP_NEG  = 2'sb11;

  typedef struct packed {
    logic               kind;
    logic [COORD_W-1:0] width;
    logic [COORD_W-1:0] height;
    logic [DEPTH_W-1:0] depth;
  } lng_cfg_t;

  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic               parity;
    logic               in_grid;
  } lng_pos_t;

  function automatic logic signed [1:0] dir_dx(input logic kind, input logic [DIR_W-1:0] dir);
    logic signed [1:0] d;
    d = STEP_ZERO;
    if (kind == KIND_TRI) begin
      case (dir)
        3'd0:    d = STEP_POS;
        3'd1:    d = STEP_ZERO;
        3'd2:    d = STEP_NEG;
        3'd3:    d = STEP_NEG;
        3'd4:    d = STEP_ZERO;
        3'd5:    d = STEP_POS;
        default: d = STEP_ZERO;
      endcase
    end else begin
      case (dir)
        3'd0:    d = STEP_POS;
        3'd1:    d = STEP_ZERO;
        3'd2:    d = STEP_NEG;
        3'd3:    d = STEP_ZERO;
        default: d = STEP_ZERO;
      endcase
    end
    return d;
  endfunction

  function automatic logic signed [1:0] dir_dy(input logic kind, input logic [DIR_W-1:0] dir);
    logic signed [1:0] d;
    d = STEP_ZERO;
    if (kind == KIND_TRI) begin
      case (dir)
        3'd0:    d = STEP_ZERO;
        3'd1:    d = STEP_NEG;
        3'd2:    d = STEP_NEG;
        3'd3:    d = STEP_ZERO;
        3'd4:    d = STEP_POS;
        3'd5:    d = STEP_POS;
        default: d = STEP_ZERO;
      endcase
    end else begin
      case (dir)
        3'd0:    d = STEP_ZERO;
        3'd1:    d = STEP_NEG;
        3'd2:    d = STEP_ZERO;
        3'd3:    d = STEP_POS;
        default: d = STEP_ZERO;
      endcase
    end
    return d;
  endfunction

endpackage

// File: rtl/lng_front.sv
// Front end: grid range check and pipelined column/row-parity divider, four bits per stage.
`timescale 1ns / 1ps

module lng_front #(
  parameter int INDEX_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         accept,
  input  logic [INDEX_BITS-1:0]        site_index,
  input  logic [lng_pkg::COORD_W-1:0]  grid_width,
  input  logic [INDEX_BITS:0]          grid_size,
  output logic                         push_valid,
  output logic [INDEX_BITS-1:0]        push_index,
  output lng_pkg::lng_pos_t            push_pos
);
  import lng_pkg::*;

  localparam int NS = (INDEX_BITS + 3) / 4;
  localparam int PW = NS * 4;

  logic                  v_r   [NS];
  logic [INDEX_BITS-1:0] p_r   [NS];
  logic [COORD_W-1:0]    rem_r [NS];
  logic                  q_r   [NS];
  logic                  ig_r  [NS];

  function automatic logic [COORD_W:0] div_step4(input logic [COORD_W-1:0] rem,
                                                  input logic [3:0] bits,
                                                  input logic [COORD_W-1:0] w);
    logic [COORD_W:0]   t;
    logic [COORD_W-1:0] r;
    logic               q;
    r = rem;
    q = 1'b0;
    for (int i = 3; i >= 0; i--) begin
      t = {r, bits[i]};
      if (t >= {1'b0, w}) begin
        t = t - {1'b0, w};
        q = 1'b1;
      end else begin
        q = 1'b0;
      end
      r = t[COORD_W-1:0];
    end
    return {r, q};
  endfunction

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic                  src_v;
    logic [INDEX_BITS-1:0] src_p;
    logic [COORD_W-1:0]    src_rem;
    logic                  src_ig;
    logic [PW-1:0]         pp;
    logic [COORD_W:0]      step;

    if (s == 0) begin : g_first
      assign src_v   = accept;
      assign src_p   = site_index;
      assign src_rem = '0;
      assign src_ig  = {1'b0, site_index} < grid_size;
    end else begin : g_next
      assign src_v   = v_r[s-1];
      assign src_p   = p_r[s-1];
      assign src_rem = rem_r[s-1];
      assign src_ig  = ig_r[s-1];
    end

    assign pp   = PW'(src_p);
    assign step = div_step4(src_rem, pp[PW-1-4*s -: 4], grid_width);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else begin
        v_r[s] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      p_r[s]   <= src_p;
      rem_r[s] <= step[COORD_W:1];
      q_r[s]   <= step[0];
      ig_r[s]  <= src_ig;
    end
  end

  assign push_valid       = v_r[NS-1];
  assign push_index       = p_r[NS-1];
  assign push_pos.col     = rem_r[NS-1];
  assign push_pos.parity  = q_r[NS-1];
  assign push_pos.in_grid = ig_r[NS-1];

endmodule

// File: rtl/lng_queue.sv
// Short queue of classified sites between the front end and the result sequencer.
`timescale 1ns / 1ps

module lng_queue #(
  parameter int INDEX_BITS = 24,
  parameter int DEPTH      = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  logic [INDEX_BITS-1:0] push_index,
  input  lng_pkg::lng_pos_t     push_pos,
  input  logic                  pop,
  output logic [INDEX_BITS-1:0] head_index,
  output lng_pkg::lng_pos_t     head_pos,
  output logic                  empty
);
  import lng_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [INDEX_BITS-1:0] idx_q [DEPTH];
  lng_pos_t              pos_q [DEPTH];
  logic [AW-1:0]         wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]         count_r;
  logic                  head_v_r;
  logic [INDEX_BITS-1:0] head_index_r;
  lng_pos_t              head_pos_r;
  logic                  load;

  assign load = (!head_v_r || pop) && (count_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
      head_v_r <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (load) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !load) begin
        count_r <= count_r + 1'b1;
      end else if (load && !push) begin
        count_r <= count_r - 1'b1;
      end
      if (!head_v_r || pop) begin
        head_v_r <= (count_r != '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      idx_q[wr_ptr_r] <= push_index;
      pos_q[wr_ptr_r] <= push_pos;
    end
    if (load) begin
      head_index_r <= idx_q[rd_ptr_r];
      head_pos_r   <= pos_q[rd_ptr_r];
    end
  end

  assign head_index = head_index_r;
  assign head_pos   = head_pos_r;
  assign empty      = !head_v_r;

endmodule

// File: rtl/lng_back.sv
// Result sequencer: walks the direction list one step a cycle and emits neighbour words.
`timescale 1ns / 1ps

module lng_back #(
  parameter int INDEX_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  lng_pkg::lng_cfg_t            cfg,
  input  logic [INDEX_BITS:0]          grid_size,
  input  logic                         q_empty,
  input  logic [INDEX_BITS-1:0]        head_index,
  input  lng_pkg::lng_pos_t            head_pos,
  output logic                         q_pop,
  output logic                         out_strobe,
  output logic [INDEX_BITS-1:0]        out_neighbour_index,
  output logic [lng_pkg::DIR_W-1:0]    out_direction,
  output logic                         out_valid_res,
  output logic                         out_last
);
  import lng_pkg::*;

  localparam int NBW = ((INDEX_BITS > COORD_W) ? INDEX_BITS : COORD_W) + 3;

  logic                  active_r;
  logic [INDEX_BITS-1:0] p_r;
  lng_pos_t              pos_r;
  logic [DIR_W-1:0]      dir_r;
  logic                  found_r;
  logic                  hold_v_r, hold_last_r, hold_vres_r;
  logic [INDEX_BITS-1:0] hold_idx_r;
  logic [DIR_W-1:0]      hold_dir_r;
  logic                  out_strobe_r, out_vres_r, out_last_r;
  logic [INDEX_BITS-1:0] out_idx_r;
  logic [DIR_W-1:0]      out_dir_r;

  logic [DIR_W-1:0]       dir_last;
  logic                   end_now;
  logic signed [1:0]      dx0, dy;
  logic signed [2:0]      dx;
  logic signed [COORD_W+1:0] nc;
  logic [NBW-1:0]         w_ext, vert, nb;
  logic                   ok_c, ok_n, cur_valid, found_any, cur_put, emit, emit_last;

  always_comb begin
    dir_last = (cfg.kind == KIND_TRI) ? NDIR_TRI - 3'd1 : NDIR_SQUARE - 3'd1;
    end_now  = active_r && (!pos_r.in_grid || dir_r == dir_last);

    dx0 = dir_dx(cfg.kind, dir_r);
    dy  = dir_dy(cfg.kind, dir_r);
    dx  = {dx0[1], dx0};
    if (cfg.kind == KIND_TRI && dy < 0) begin
      dx = dx + $signed({2'b00, !pos_r.parity});
    end else if (cfg.kind == KIND_TRI && dy > 0) begin
      dx = dx - $signed({2'b00, pos_r.parity});
    end

    nc   = $signed({2'b00, pos_r.col}) + {{(COORD_W - 1){dx[2]}}, dx};
    ok_c = !nc[COORD_W+1] && (nc[COORD_W:0] < {1'b0, cfg.width});

    w_ext = NBW'(cfg.width);
    if (dy < 0) begin
      vert = -w_ext;
    end else if (dy > 0) begin
      vert = w_ext;
    end else begin
      vert = '0;
    end
    nb   = NBW'(p_r) + vert + {{(NBW - 3){dx[2]}}, dx};
    ok_n = !nb[NBW-1] && (nb < NBW'(grid_size));

    cur_valid = active_r && pos_r.in_grid && ok_c && ok_n;
    found_any = found_r || cur_valid;
    cur_put   = cur_valid || (end_now && !found_any);
    emit      = hold_v_r && (hold_last_r || cur_put || end_now);
    emit_last = hold_last_r || (end_now && !cur_put);
    q_pop     = (!active_r || end_now) && !q_empty;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r     <= 1'b0;
      hold_v_r     <= 1'b0;
      hold_last_r  <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      if (!active_r || end_now) begin
        active_r <= !q_empty;
      end
      if (cur_put) begin
        hold_v_r    <= 1'b1;
        hold_last_r <= end_now;
      end else if (emit) begin
        hold_v_r    <= 1'b0;
        hold_last_r <= 1'b0;
      end
      out_strobe_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      p_r     <= head_index;
      pos_r   <= head_pos;
      dir_r   <= '0;
      found_r <= 1'b0;
    end else if (active_r) begin
      dir_r   <= dir_r + 1'b1;
      found_r <= found_any;
    end
    if (cur_put) begin
      hold_idx_r  <= cur_valid ? nb[INDEX_BITS-1:0] : '0;
      hold_dir_r  <= cur_valid ? dir_r : '0;
      hold_vres_r <= cur_valid;
    end
    if (emit) begin
      out_idx_r  <= hold_idx_r;
      out_dir_r  <= hold_dir_r;
      out_vres_r <= hold_vres_r;
      out_last_r <= emit_last;
    end
  end

  assign out_strobe          = out_strobe_r;
  assign out_neighbour_index = out_idx_r;
  assign out_direction       = out_dir_r;
  assign out_valid_res       = out_vres_r;
  assign out_last            = out_last_r;

endmodule

// File: rtl/lattice_neighbour_generator.sv
// Top level: register file, grid size product, credit control and the front/queue/back chain.
`timescale 1ns / 1ps

// A site word is taken when start is high and busy is low, and can follow in the next
// cycle while earlier sites are still in the divider or the queue. Each site yields its
// neighbour words at most one per cycle, each on the out_ ports for one cycle under
// out_strobe; the receiver cannot stall them. Sustained rate is set by the result sequencer
// that walks the direction list: four directions per site on a square grid, six on a
// triangular grid, and only the first step for a site outside the grid. From accept, a
// site passes the ceil(INDEX_BITS/4) divider stages, the queue and its head register, the
// sequencer's site registers, a one-word hold stage and the out_ registers; a found
// neighbour waits in the hold stage until the next one or the end of the list marks it.
// busy rises while the queue and the divider together hold ceil(INDEX_BITS/4)+2 sites, and
// after any register write while the grid size product settles through wh_r and whd_r.
module lattice_neighbour_generator #(
  parameter int INDEX_BITS = 24
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [INDEX_BITS-1:0]       in_site_index,
  output logic                        out_strobe,
  output logic [INDEX_BITS-1:0]       out_neighbour_index,
  output logic [lng_pkg::DIR_W-1:0]   out_direction,
  output logic                        out_valid_res,
  output logic                        out_last,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lng_pkg::ADDR_W-1:0]  paddr,
  input  logic [lng_pkg::DATA_W-1:0]  pwdata,
  output logic [lng_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import lng_pkg::*;

  localparam int NS  = (INDEX_BITS + 3) / 4;
  localparam int QD  = NS + 2;
  localparam int QCW = $clog2(QD + 1);
  localparam int MW  = (INDEX_BITS + 1 > PROD_W) ? INDEX_BITS + 1 : PROD_W;

  logic                    kind_r;
  logic [COORD_W-1:0]      width_r, height_r;
  logic [DEPTH_W-1:0]      depth_r;
  logic [2*COORD_W-1:0]    wh_r;
  logic [PROD_W-1:0]       whd_r;
  logic [1:0]              settle_r;
  logic [QCW-1:0]          inflight_r, inflight_nxt;

  lng_cfg_t                cfg;
  logic [MW-1:0]           whd_ext, size_limit;
  logic [INDEX_BITS:0]     grid_size;
  logic                    wr_en, accept;
  logic                    push_valid, q_pop, q_empty;
  logic [INDEX_BITS-1:0]   push_index, head_index;
  lng_pos_t                push_pos, head_pos;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r   <= KIND_SQUARE;
      width_r  <= COORD_W'(1);
      height_r <= COORD_W'(1);
      depth_r  <= DEPTH_W'(1);
      wh_r     <= (2*COORD_W)'(1);
      whd_r    <= PROD_W'(1);
      settle_r <= 2'd0;
    end else begin
      if (wr_en) begin
        case (paddr[ADDR_W-1:2])
          REG_KIND:   kind_r   <= pwdata[0];
          REG_WIDTH:  width_r  <= pwdata[COORD_W-1:0];
          REG_HEIGHT: height_r <= pwdata[COORD_W-1:0];
          REG_DEPTH:  depth_r  <= pwdata[DEPTH_W-1:0];
          default:    ;
        endcase
      end
      wh_r  <= width_r * height_r;
      whd_r <= wh_r * depth_r;
      if (wr_en) begin
        settle_r <= 2'd2;
      end else if (settle_r != 2'd0) begin
        settle_r <= settle_r - 2'd1;
      end
    end
  end

  always_comb begin
    case (paddr[ADDR_W-1:2])
      REG_KIND:   prdata = DATA_W'(kind_r);
      REG_WIDTH:  prdata = DATA_W'(width_r);
      REG_HEIGHT: prdata = DATA_W'(height_r);
      REG_DEPTH:  prdata = DATA_W'(depth_r);
      default:    prdata = '0;
    endcase
  end

  assign cfg.kind   = kind_r;
  assign cfg.width  = width_r;
  assign cfg.height = height_r;
  assign cfg.depth  = depth_r;

  assign whd_ext    = MW'(whd_r);
  assign size_limit = MW'(1) << INDEX_BITS;
  assign grid_size  = (whd_ext > size_limit) ? size_limit[INDEX_BITS:0] : whd_ext[INDEX_BITS:0];

  assign busy   = (settle_r != 2'd0) || (inflight_r == QCW'(QD));
  assign accept = start && !busy;

  always_comb begin
    inflight_nxt = inflight_r;
    if (accept && !q_pop) begin
      inflight_nxt = inflight_r + 1'b1;
    end else if (q_pop && !accept) begin
      inflight_nxt = inflight_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else begin
      inflight_r <= inflight_nxt;
    end
  end

  lng_front #(
    .INDEX_BITS(INDEX_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .site_index (in_site_index),
    .grid_width (width_r),
    .grid_size  (grid_size),
    .push_valid (push_valid),
    .push_index (push_index),
    .push_pos   (push_pos)
  );

  lng_queue #(
    .INDEX_BITS(INDEX_BITS),
    .DEPTH     (QD)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push_valid),
    .push_index (push_index),
    .push_pos   (push_pos),
    .pop        (q_pop),
    .head_index (head_index),
    .head_pos   (head_pos),
    .empty      (q_empty)
  );

  lng_back #(
    .INDEX_BITS(INDEX_BITS)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg                 (cfg),
    .grid_size           (grid_size),
    .q_empty             (q_empty),
    .head_index          (head_index),
    .head_pos            (head_pos),
    .q_pop               (q_pop),
    .out_strobe          (out_strobe),
    .out_neighbour_index (out_neighbour_index),
    .out_direction       (out_direction),
    .out_valid_res       (out_valid_res),
    .out_last            (out_last)
  );

endmodule
